[sv/assert_macros.svh]
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ipfe_pkg.sv]
// Package: types, constants and word gathering for the IMU packet field extractor
`default_nettype none
package ipfe_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned ASM_W   = 24;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned QTY_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUS_ID   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_ID  = 2'd2;

  localparam logic [BYTE_W-1:0] PREAMBLE_RESET = 8'd250;
  localparam logic [BYTE_W-1:0] BUS_ID_RESET   = 8'd255;
  localparam logic [BYTE_W-1:0] DATA_ID_RESET  = 8'd54;
  localparam logic [BYTE_W-1:0] LENGTH_RESET   = 8'd5;

  // Frame layout
  localparam logic [POS_W-1:0]   POS_PREAMBLE    = 9'd1;
  localparam logic [POS_W-1:0]   POS_BUS_ID      = 9'd2;
  localparam logic [POS_W-1:0]   POS_MSG_ID      = 9'd3;
  localparam logic [POS_W-1:0]   POS_LENGTH      = 9'd4;
  localparam logic [POS_W-1:0]   POS_ANGLE_MARK  = 9'd7;
  localparam logic [POS_W-1:0]   POS_ANGLE_FIRST = 9'd8;
  localparam logic [POS_W-1:0]   POS_ACCEL_FIRST = 9'd23;
  localparam logic [POS_W-1:0]   FRAME_OVERHEAD  = 9'd4;
  localparam logic [BYTE_W-1:0]  ANGLE_MARK      = 8'h0C;
  localparam logic [COUNT_W-1:0] WORD_SET_BYTES  = 4'd12;
  localparam logic [QTY_W-1:0]   ACCEL_QTY_BASE  = 3'd3;

  localparam logic [1:0] HDR_NONE = 2'd0;
  localparam logic [1:0] HDR_BUS  = 2'd2;
  localparam logic [1:0] HDR_FULL = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] preamble_byte;
    logic [BYTE_W-1:0] bus_id_byte;
    logic [BYTE_W-1:0] data_message_id;
  } cfg_t;

  typedef struct packed {
    logic              have;
    logic [QTY_W-1:0]  quantity;
    logic [WORD_W-1:0] value_bits;
  } result_t;

  typedef struct packed {
    logic              done;
    logic [1:0]        index;
    logic [WORD_W-1:0] word;
    logic [ASM_W-1:0]  assembly;
  } gather_t;

  // Place one byte into the word under assembly; the fourth byte completes it
  function automatic gather_t gather(input logic [COUNT_W-1:0] left,
                                     input logic [BYTE_W-1:0]  b,
                                     input logic [ASM_W-1:0]   wa);
    gather_t            g;
    logic [COUNT_W-1:0] done_bytes;
    done_bytes = COUNT_W'(WORD_SET_BYTES - left);
    g.done     = 1'b0;
    g.index    = done_bytes[3:2];
    g.word     = {wa, b};
    g.assembly = wa;
    case (done_bytes[1:0])
      2'd0: g.assembly[23:16] = b;
      2'd1: g.assembly[15:8]  = b;
      2'd2: g.assembly[7:0]   = b;
      2'd3: begin
        g.done     = 1'b1;
        g.assembly = '0;
      end
      default: g.assembly = wa;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

[sv/ipfe_in_reg.sv]
// Input register: holds one received byte until the parser takes it
`default_nettype none
module ipfe_in_reg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [ipfe_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic                       out_free,
  output logic                            step,
  output logic [ipfe_pkg::BYTE_W-1:0]     byte_q
);

  logic held;

  assign step     = held && out_free;
  assign in_ready = !held || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

endmodule
`default_nettype wire

[sv/ipfe_parser.sv]
// Frame parser: header check, position tracking and word gathering, one byte per step
`default_nettype none
module ipfe_parser (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic [ipfe_pkg::BYTE_W-1:0] byte_q,
  input  wire ipfe_pkg::cfg_t              cfg,
  output ipfe_pkg::result_t                res
);

  logic [ipfe_pkg::POS_W-1:0]   byte_position, byte_position_next;
  logic [1:0]                   header_matches, header_matches_next;
  logic [ipfe_pkg::BYTE_W-1:0]  message_id, message_id_next;
  logic [ipfe_pkg::BYTE_W-1:0]  payload_length, payload_length_next;
  logic [ipfe_pkg::COUNT_W-1:0] angle_left, angle_left_next;
  logic [ipfe_pkg::COUNT_W-1:0] accel_left, accel_left_next;
  logic [ipfe_pkg::ASM_W-1:0]   word_assembly, word_assembly_next;

  logic [ipfe_pkg::POS_W-1:0]   pos;
  ipfe_pkg::gather_t            angle_g, accel_g;

  always_comb begin
    pos                 = byte_position + 9'd1;
    byte_position_next  = pos;
    header_matches_next = header_matches;
    message_id_next     = message_id;
    payload_length_next = payload_length;
    angle_left_next     = angle_left;
    accel_left_next     = accel_left;
    word_assembly_next  = word_assembly;
    angle_g             = '0;
    accel_g             = '0;
    res                 = '0;

    if (byte_q == cfg.preamble_byte && pos == ipfe_pkg::POS_PREAMBLE) begin
      header_matches_next = header_matches + 2'd1;
    end else if (byte_q == cfg.bus_id_byte && pos == ipfe_pkg::POS_BUS_ID) begin
      header_matches_next = header_matches + 2'd1;
    end else if (pos == ipfe_pkg::POS_MSG_ID && header_matches == ipfe_pkg::HDR_BUS) begin
      header_matches_next = ipfe_pkg::HDR_FULL;
      message_id_next     = byte_q;
    end else if (header_matches == ipfe_pkg::HDR_FULL &&
                 message_id == cfg.data_message_id) begin
      if (pos == ipfe_pkg::POS_LENGTH) begin
        payload_length_next = byte_q;
      end
      // Angle marker (re)arms the angle words
      if (pos == ipfe_pkg::POS_ANGLE_MARK && byte_q == ipfe_pkg::ANGLE_MARK) begin
        angle_left_next = ipfe_pkg::WORD_SET_BYTES;
      end
      if (angle_left_next != '0 && pos >= ipfe_pkg::POS_ANGLE_FIRST) begin
        angle_g            = ipfe_pkg::gather(angle_left_next, byte_q, word_assembly_next);
        word_assembly_next = angle_g.assembly;
        if (angle_g.done) begin
          res.have       = 1'b1;
          res.quantity   = {1'b0, angle_g.index};
          res.value_bits = angle_g.word;
          if (angle_left_next == 4'd1) begin
            accel_left_next = ipfe_pkg::WORD_SET_BYTES;
          end
        end
        angle_left_next = angle_left_next - 4'd1;
      end
      if (pos >= ipfe_pkg::POS_ACCEL_FIRST && accel_left_next != '0) begin
        accel_g            = ipfe_pkg::gather(accel_left_next, byte_q, word_assembly_next);
        word_assembly_next = accel_g.assembly;
        accel_left_next    = accel_left_next - 4'd1;
        if (accel_g.done && !res.have) begin
          res.have       = 1'b1;
          res.quantity   = ipfe_pkg::ACCEL_QTY_BASE + {1'b0, accel_g.index};
          res.value_bits = accel_g.word;
        end
      end
    end else begin
      byte_position_next  = '0;
      header_matches_next = ipfe_pkg::HDR_NONE;
    end

    // End of frame
    if (byte_position_next == {1'b0, payload_length_next} + ipfe_pkg::FRAME_OVERHEAD) begin
      byte_position_next  = '0;
      header_matches_next = ipfe_pkg::HDR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      header_matches <= ipfe_pkg::HDR_NONE;
      message_id     <= '0;
      payload_length <= ipfe_pkg::LENGTH_RESET;
      angle_left     <= '0;
      accel_left     <= '0;
      word_assembly  <= '0;
    end else if (step) begin
      byte_position  <= byte_position_next;
      header_matches <= header_matches_next;
      message_id     <= message_id_next;
      payload_length <= payload_length_next;
      angle_left     <= angle_left_next;
      accel_left     <= accel_left_next;
      word_assembly  <= word_assembly_next;
    end
  end

endmodule
`default_nettype wire

[sv/ipfe_out_reg.sv]
// Result register: holds one finished word until the consumer takes it
`default_nettype none
module ipfe_out_reg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire ipfe_pkg::result_t           res,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic                             out_free,
  output logic [ipfe_pkg::QTY_W-1:0]       quantity,
  output logic [ipfe_pkg::WORD_W-1:0]      value_bits
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res.have;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.have) begin
      quantity   <= res.quantity;
      value_bits <= res.value_bits;
    end
  end

endmodule
`default_nettype wire

[sv/imu_packet_field_extractor.sv]
// Top level of the IMU packet field extractor
// Takes one received serial byte per transaction and reports the IEEE-754 single
// words of a data frame: three angle words (quantity 0-2) when byte 7 is 0x0C,
// then three acceleration words (quantity 3-5) from byte 23 on, each word built
// big-endian from four bytes. Bytes 1 and 2 must match the preamble and bus id
// registers and byte 3 must equal the data message id, otherwise the frame
// position drops back to zero; byte 4 gives the payload length and the frame
// closes after byte length+4. A byte that completes no word yields no result.
// Rate: one byte per clock cycle, sustained. A byte accepted at a clock edge sits
// in the input register, is parsed against the frame state when the result register
// can take a word, and its word, if any, is loaded into the result register as the
// frame state updates. The frame state update per byte is what sets the rate.
// The result register lets the next byte in while a finished word still waits;
// only a stalled result with a byte already held stops the input.
// Configuration: write cfg_data[7:0] to register cfg_index (0 preamble, 1 bus id,
// 2 data message id) while no transaction is in flight; index 3 is ignored.
`default_nettype none
module imu_packet_field_extractor (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [ipfe_pkg::BYTE_W-1:0]     rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [ipfe_pkg::QTY_W-1:0]           quantity,
  output logic [ipfe_pkg::WORD_W-1:0]          value_bits,
  input  wire logic                            cfg_write,
  input  wire logic [ipfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ipfe_pkg::BYTE_W-1:0]     cfg_data
);

  ipfe_pkg::cfg_t              cfg;
  ipfe_pkg::result_t           res;
  logic                        step;
  logic                        out_free;
  logic [ipfe_pkg::BYTE_W-1:0] byte_q;

  // Configuration registers; drop writes to unused indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preamble_byte   <= ipfe_pkg::PREAMBLE_RESET;
      cfg.bus_id_byte     <= ipfe_pkg::BUS_ID_RESET;
      cfg.data_message_id <= ipfe_pkg::DATA_ID_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ipfe_pkg::REG_PREAMBLE: cfg.preamble_byte   <= cfg_data;
        ipfe_pkg::REG_BUS_ID:   cfg.bus_id_byte     <= cfg_data;
        ipfe_pkg::REG_DATA_ID:  cfg.data_message_id <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the incoming byte; advance it whenever the result register can take a word
  ipfe_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .out_free (out_free),
    .step     (step),
    .byte_q   (byte_q)
  );

  // Parse the held byte and update the frame state
  ipfe_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .byte_q (byte_q),
    .cfg    (cfg),
    .res    (res)
  );

  // Hold a finished word until the consumer takes the transaction
  ipfe_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .res        (res),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_free   (out_free),
    .quantity   (quantity),
    .value_bits (value_bits)
  );

endmodule
`default_nettype wire

[sv/ipfe_checker.sv]
// Port-level checker for the IMU packet field extractor, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module ipfe_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [ipfe_pkg::QTY_W-1:0]      quantity,
  input wire logic [ipfe_pkg::WORD_W-1:0]     value_bits
);

  logic in_take;
  assign in_take = in_valid && in_ready;

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(quantity) && $stable(value_bits), "stalled result changed")
  `ASSERT_IMPL(a_qty_range, clk, rst, out_valid, quantity <= 3'd5, "quantity out of range")
  `ASSERT_IMPL(a_ready_empty, clk, rst, !in_ready, out_valid && !out_ready, "input stalled without a stalled result")
  `ASSERT_IMPL(a_result_cause, clk, rst, $rose(out_valid), $past(in_take, 2), "result without an accepted byte")

endmodule

bind imu_packet_field_extractor ipfe_checker u_checker (.*);
`default_nettype wire
